@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// shared widths, action and status codes for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  // operand format: signed fixed point, DW bits with FB fraction bits
  localparam int DW = 32;
  localparam int FB = 16;

  // internal widths
  localparam int PW   = 2 * DW;        // one product
  localparam int SW   = 2 * DW + 2;    // sum of two products, signed
  localparam int MW   = 2 * DW + 1;    // magnitude of such a sum
  localparam int DENW = 2 * DW + 1;    // c^2 + d^2
  localparam int D2W  = DENW + 1;      // twice the denominator
  localparam int XW   = MW + FB + 2;   // scaled dividend
  localparam int QB   = DW;            // quotient bits, one per divider stage

  // stream widths
  localparam int IN_TDATA_W  = ((4 * DW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * DW + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TUSER_W = 3;

  // rounding step and saturation limits
  localparam logic [MW-1:0] RND     = (MW'(1) << FB) >> 1;
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (DW - 1);
  localparam logic [MW-1:0] LIM_POS = (MW'(1) << (DW - 1)) - MW'(1);

  // action codes
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_EQ  = 3'd4;
  localparam logic [2:0] ACT_NE  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // per-item control and finished non-divide result riding beside the divider
  typedef struct packed {
    logic          vld;
    logic          is_div;
    logic          dz;
    logic          ovf_re;
    logic          ovf_im;
    logic          neg_re;
    logic          neg_im;
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic          cmp;
    logic [1:0]    status;
  } side_t;

endpackage

@@ rtl/cau_div_pipe.sv @@
// ----------------------------------------------------------------------------
// cau_div_pipe
// restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module cau_div_pipe (
  input  logic                     clk,
  input  logic                     en,
  input  logic [cau_pkg::D2W-1:0]  rem_i,
  input  logic [cau_pkg::QB-1:0]   x_i,
  input  logic [cau_pkg::D2W-1:0]  d_i,
  output logic [cau_pkg::QB-1:0]   q_o
);

  logic [cau_pkg::D2W-1:0] rem_r [cau_pkg::QB-1];
  logic [cau_pkg::QB-1:0]  x_r   [cau_pkg::QB-1];
  logic [cau_pkg::D2W-1:0] d_r   [cau_pkg::QB-1];
  logic [cau_pkg::QB-1:0]  q_r   [cau_pkg::QB];

  for (genvar k = 0; k < cau_pkg::QB; k++) begin : g_stage
    logic [cau_pkg::D2W-1:0] rem_in;
    logic [cau_pkg::D2W-1:0] d_in;
    logic [cau_pkg::QB-1:0]  x_in;
    logic [cau_pkg::QB-1:0]  q_in;
    logic [cau_pkg::D2W:0]   t;
    logic                    ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign d_in   = d_i;
      assign x_in   = x_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign x_in   = x_r[k-1];
      assign q_in   = q_r[k-1];
    end

    // shift in the next dividend bit, then trial subtract
    assign t  = {rem_in, x_in[cau_pkg::QB-1]};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_in[cau_pkg::QB-2:0], ge};
      end
    end

    if (k < cau_pkg::QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? cau_pkg::D2W'(t - {1'b0, d_in}) : cau_pkg::D2W'(t);
          x_r[k]   <= x_in << 1;
          d_r[k]   <= d_in;
        end
      end
    end
  end

  assign q_o = q_r[cau_pkg::QB-1];

endmodule

@@ rtl/complex_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// pipelined complex add, subtract, multiply, divide and compare, fixed point
// ----------------------------------------------------------------------------
// usage
//   in_*  : one transaction carries an action code on in_tuser and the two
//           complex operands on in_tdata; accepted when in_tvalid & in_tready
//   out_* : one result transaction per input transaction, in the same order;
//           result parts on out_tdata, compare flag and status on out_tuser
//   stages: six front stages (input register, multipliers, product sums,
//           magnitudes, scaling, divider setup), one divider stage per
//           quotient bit and the output register
//   throughput: one transaction per cycle while in_tready is high, every action takes the same path
//   reset: rst_n low empties every stage and the output buffer; in_tready is
//           high from the first cycle after reset
//   stall: the output buffer holds two results; while out_tready is low the
//           pipeline keeps moving until the spare slot fills, then in_tready
//           drops and every stage holds its contents
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // fields from bit 0 up: a_re, a_im, b_re, b_im, zero padding
  input  logic [cau_pkg::IN_TDATA_W-1:0]   in_tdata,
  // fields from bit 0 up: action
  input  logic [cau_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // fields from bit 0 up: result_re, result_im, zero padding
  output logic [cau_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // fields from bit 0 up: compare_true, status
  output logic [cau_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  localparam int DW = cau_pkg::DW;
  localparam int QB = cau_pkg::QB;

  // clamp a magnitude to the signed range and apply the sign; returns {sat, field}
  function automatic logic [DW:0] sat_field(input logic [cau_pkg::MW-1:0] m,
                                            input logic neg,
                                            input logic force_sat);
    logic [cau_pkg::MW-1:0] lim;
    logic [cau_pkg::MW-1:0] mm;
    logic                   sat;
    lim = neg ? cau_pkg::LIM_NEG : cau_pkg::LIM_POS;
    sat = force_sat || (m > lim);
    mm  = sat ? lim : m;
    return {sat, neg ? DW'(-mm) : DW'(mm)};
  endfunction

  // whole pipeline advances unless the spare output slot is occupied
  logic en;
  logic spare_v_r;
  assign en        = !spare_v_r;
  assign in_tready = en;

  // stage 0: input register
  logic                 v0_r;
  logic [2:0]           act0_r;
  logic signed [DW-1:0] ar0_r, ai0_r, br0_r, bi0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r   <= in_tvalid;
      act0_r <= in_tuser;
      ar0_r  <= in_tdata[DW-1:0];
      ai0_r  <= in_tdata[2*DW-1:DW];
      br0_r  <= in_tdata[3*DW-1:2*DW];
      bi0_r  <= in_tdata[4*DW-1:3*DW];
    end
  end

  // stage 1: six products, add/sub, compare
  logic                          v1_r;
  logic [2:0]                    act1_r;
  logic                          cmp1_r;
  logic signed [cau_pkg::PW-1:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r, p_cc_r, p_dd_r;
  logic signed [DW:0]            as_re1_r, as_im1_r;
  logic                          eq0;
  logic                          cmp0;
  logic signed [DW:0]            ar0_x, ai0_x, br0_x, bi0_x;

  assign eq0   = (ar0_r == br0_r) && (ai0_r == bi0_r);
  assign cmp0  = (act0_r == cau_pkg::ACT_EQ) ? eq0 :
                 (act0_r == cau_pkg::ACT_NE) ? !eq0 : 1'b0;
  assign ar0_x = (DW+1)'(ar0_r);
  assign ai0_x = (DW+1)'(ai0_r);
  assign br0_x = (DW+1)'(br0_r);
  assign bi0_x = (DW+1)'(bi0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r     <= v0_r;
      act1_r   <= act0_r;
      cmp1_r   <= cmp0;
      p_ac_r   <= ar0_r * br0_r;
      p_bd_r   <= ai0_r * bi0_r;
      p_ad_r   <= ar0_r * bi0_r;
      p_bc_r   <= ai0_r * br0_r;
      p_cc_r   <= br0_r * br0_r;
      p_dd_r   <= bi0_r * bi0_r;
      as_re1_r <= (act0_r == cau_pkg::ACT_SUB) ? ar0_x - br0_x : ar0_x + br0_x;
      as_im1_r <= (act0_r == cau_pkg::ACT_SUB) ? ai0_x - bi0_x : ai0_x + bi0_x;
    end
  end

  // stage 2: sums of products and the denominator
  logic                            v2_r;
  logic [2:0]                      act2_r;
  logic                            cmp2_r;
  logic signed [cau_pkg::SW-1:0]   s_re2_r, s_im2_r;
  logic [cau_pkg::DENW-1:0]        den2_r;
  logic signed [cau_pkg::SW-1:0]   s_re1, s_im1;

  always_comb begin
    case (act1_r)
      cau_pkg::ACT_MUL: begin
        s_re1 = cau_pkg::SW'(p_ac_r) - cau_pkg::SW'(p_bd_r);
        s_im1 = cau_pkg::SW'(p_ad_r) + cau_pkg::SW'(p_bc_r);
      end
      cau_pkg::ACT_DIV: begin
        s_re1 = cau_pkg::SW'(p_ac_r) + cau_pkg::SW'(p_bd_r);
        s_im1 = cau_pkg::SW'(p_bc_r) - cau_pkg::SW'(p_ad_r);
      end
      default: begin
        s_re1 = cau_pkg::SW'(as_re1_r);
        s_im1 = cau_pkg::SW'(as_im1_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r    <= v1_r;
      act2_r  <= act1_r;
      cmp2_r  <= cmp1_r;
      s_re2_r <= s_re1;
      s_im2_r <= s_im1;
      den2_r  <= cau_pkg::DENW'($unsigned(p_cc_r)) + cau_pkg::DENW'($unsigned(p_dd_r));
    end
  end

  // stage 3: sign and magnitude
  logic                     v3_r;
  logic [2:0]               act3_r;
  logic                     cmp3_r;
  logic                     neg_re3_r, neg_im3_r, dz3_r;
  logic [cau_pkg::MW-1:0]   mag_re3_r, mag_im3_r;
  logic [cau_pkg::DENW-1:0] den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r      <= v2_r;
      act3_r    <= act2_r;
      cmp3_r    <= cmp2_r;
      neg_re3_r <= s_re2_r[cau_pkg::SW-1];
      neg_im3_r <= s_im2_r[cau_pkg::SW-1];
      mag_re3_r <= s_re2_r[cau_pkg::SW-1] ? cau_pkg::MW'(-s_re2_r) : cau_pkg::MW'(s_re2_r);
      mag_im3_r <= s_im2_r[cau_pkg::SW-1] ? cau_pkg::MW'(-s_im2_r) : cau_pkg::MW'(s_im2_r);
      dz3_r     <= (den2_r == '0);
      den3_r    <= den2_r;
    end
  end

  // stage 4: rounding for multiply, scaled dividend for divide
  logic                    v4_r;
  logic [2:0]              act4_r;
  logic                    cmp4_r;
  logic                    neg_re4_r, neg_im4_r, dz4_r;
  logic [cau_pkg::MW-1:0]  rnd_re4_r, rnd_im4_r;
  logic [cau_pkg::XW-1:0]  x_re4_r, x_im4_r;
  logic [cau_pkg::D2W-1:0] d2_4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r      <= v3_r;
      act4_r    <= act3_r;
      cmp4_r    <= cmp3_r;
      neg_re4_r <= neg_re3_r;
      neg_im4_r <= neg_im3_r;
      dz4_r     <= dz3_r;
      if (act3_r == cau_pkg::ACT_MUL) begin
        rnd_re4_r <= cau_pkg::MW'((mag_re3_r + cau_pkg::RND) >> cau_pkg::FB);
        rnd_im4_r <= cau_pkg::MW'((mag_im3_r + cau_pkg::RND) >> cau_pkg::FB);
      end else begin
        rnd_re4_r <= mag_re3_r;
        rnd_im4_r <= mag_im3_r;
      end
      // round(n * 2^FB / den) = floor((n * 2^(FB+1) + den) / (2 * den))
      x_re4_r <= (cau_pkg::XW'(mag_re3_r) << (cau_pkg::FB + 1)) + cau_pkg::XW'(den3_r);
      x_im4_r <= (cau_pkg::XW'(mag_im3_r) << (cau_pkg::FB + 1)) + cau_pkg::XW'(den3_r);
      d2_4_r  <= {den3_r, 1'b0};
    end
  end

  // stage 5: finish non-divide results, set up the divider
  cau_pkg::side_t          side_r [QB+1];
  cau_pkg::side_t          side5;
  logic [cau_pkg::D2W-1:0] rem_re5_r, rem_im5_r, d2_5_r;
  logic [QB-1:0]           xl_re5_r, xl_im5_r;
  logic [DW:0]             fr_re4, fr_im4;

  assign fr_re4 = sat_field(rnd_re4_r, neg_re4_r, 1'b0);
  assign fr_im4 = sat_field(rnd_im4_r, neg_im4_r, 1'b0);

  always_comb begin
    side5        = '0;
    side5.vld    = v4_r;
    side5.dz     = dz4_r;
    side5.neg_re = neg_re4_r;
    side5.neg_im = neg_im4_r;
    // quotient needs more than QB bits when the top of the dividend reaches the divisor
    side5.ovf_re = (x_re4_r >> QB) >= cau_pkg::XW'(d2_4_r);
    side5.ovf_im = (x_im4_r >> QB) >= cau_pkg::XW'(d2_4_r);
    case (act4_r) inside
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_MUL: begin
        side5.re     = fr_re4[DW-1:0];
        side5.im     = fr_im4[DW-1:0];
        side5.status = (fr_re4[DW] || fr_im4[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::ACT_DIV: begin
        side5.is_div = 1'b1;
      end
      cau_pkg::ACT_EQ, cau_pkg::ACT_NE: begin
        side5.cmp = cmp4_r;
      end
      default: begin
        side5.cmp = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re5_r <= cau_pkg::D2W'(x_re4_r >> QB);
      rem_im5_r <= cau_pkg::D2W'(x_im4_r >> QB);
      xl_re5_r  <= x_re4_r[QB-1:0];
      xl_im5_r  <= x_im4_r[QB-1:0];
      d2_5_r    <= d2_4_r;
    end
  end

  // control delay line, one entry for the divider setup stage and one per divider stage
  for (genvar i = 0; i <= QB; i++) begin : g_side
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_r[i].vld <= 1'b0;
        end else if (en) begin
          side_r[i] <= side5;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_r[i].vld <= 1'b0;
        end else if (en) begin
          side_r[i] <= side_r[i-1];
        end
      end
    end
  end

  // divider lanes for real and imaginary part
  logic [QB-1:0] q_re, q_im;

  cau_div_pipe u_div_re (
    .clk   (clk),
    .en    (en),
    .rem_i (rem_re5_r),
    .x_i   (xl_re5_r),
    .d_i   (d2_5_r),
    .q_o   (q_re)
  );

  cau_div_pipe u_div_im (
    .clk   (clk),
    .en    (en),
    .rem_i (rem_im5_r),
    .x_i   (xl_im5_r),
    .d_i   (d2_5_r),
    .q_o   (q_im)
  );

  // final assembly
  cau_pkg::side_t last;
  logic [DW:0]    fq_re, fq_im;
  logic [DW-1:0]  fin_re, fin_im;
  logic           fin_cmp;
  logic [1:0]     fin_st;
  logic           push;

  assign last  = side_r[QB];
  assign fq_re = sat_field(cau_pkg::MW'(q_re), last.neg_re, last.ovf_re);
  assign fq_im = sat_field(cau_pkg::MW'(q_im), last.neg_im, last.ovf_im);
  assign push  = en && last.vld;

  always_comb begin
    fin_re  = last.re;
    fin_im  = last.im;
    fin_cmp = last.cmp;
    fin_st  = last.status;
    if (last.is_div) begin
      if (last.dz) begin
        fin_re = '0;
        fin_im = '0;
        fin_st = cau_pkg::ST_DIVZ;
      end else begin
        fin_re = fq_re[DW-1:0];
        fin_im = fq_im[DW-1:0];
        fin_st = (fq_re[DW] || fq_im[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  // two-slot output buffer
  logic          main_v_r;
  logic [DW-1:0] main_re_r, main_im_r, spare_re_r, spare_im_r;
  logic          main_cmp_r, spare_cmp_r;
  logic [1:0]    main_st_r, spare_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (!main_v_r || out_tready) begin
      if (spare_v_r) begin
        main_v_r   <= 1'b1;
        spare_v_r  <= 1'b0;
        main_re_r  <= spare_re_r;
        main_im_r  <= spare_im_r;
        main_cmp_r <= spare_cmp_r;
        main_st_r  <= spare_st_r;
      end else begin
        main_v_r   <= push;
        main_re_r  <= fin_re;
        main_im_r  <= fin_im;
        main_cmp_r <= fin_cmp;
        main_st_r  <= fin_st;
      end
    end else if (push) begin
      spare_v_r   <= 1'b1;
      spare_re_r  <= fin_re;
      spare_im_r  <= fin_im;
      spare_cmp_r <= fin_cmp;
      spare_st_r  <= fin_st;
    end
  end

  assign out_tvalid = main_v_r;
  assign out_tdata  = cau_pkg::OUT_TDATA_W'({main_im_r, main_re_r});
  assign out_tuser  = {main_st_r, main_cmp_r};

endmodule

@@ rtl/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker
// port-level checks for the complex arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
module cau_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [cau_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [cau_pkg::IN_TUSER_W-1:0]   in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cau_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [cau_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  logic [1:0] st;
  assign st = out_tuser[2:1];

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only defined status codes appear
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == cau_pkg::ST_OK) || (st == cau_pkg::ST_DIVZ) || (st == cau_pkg::ST_SAT))
    else $error("undefined status code");

  // divide by zero gives a zero result and no compare flag
  a_divz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == cau_pkg::ST_DIVZ) |-> (out_tdata == '0) && !out_tuser[0])
    else $error("divide by zero result not cleared");

  // compare flag only with zero result and ok status
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && (st == cau_pkg::ST_OK))
    else $error("compare result carries data or status");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);

@@ sim/complex_arithmetic_unit_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top_tb
// self-checking bench for the complex arithmetic unit: directed corner cases,
// then random operands under random idling and backpressure, each result
// checked field by field against an exact fixed-point calculation
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top_tb;

  localparam int DW          = cau_pkg::DW;
  localparam int FB          = cau_pkg::FB;
  localparam int IN_TDATA_W  = cau_pkg::IN_TDATA_W;
  localparam int IN_TUSER_W  = cau_pkg::IN_TUSER_W;
  localparam int OUT_TDATA_W = cau_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W = cau_pkg::OUT_TUSER_W;

  localparam int N_RANDOM   = 800;
  localparam int MAX_CYCLES = 300000;
  localparam int TAIL       = 2 * (DW + 7) + 10;

  typedef struct {
    logic [2:0]    action;
    logic [DW-1:0] a_re, a_im, b_re, b_im;
    bit            drain_first;  // wait until all results are back before offering
  } op_t;

  typedef struct {
    logic [DW-1:0] re, im;
    logic          cmp;
    logic [1:0]    status;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  op_t  pending_ops[$];
  res_t expected_res[$];
  int   n_errors = 0;
  int   n_accepted = 0;
  int   cycle = 0;
  bit   taken = 1'b0;      // set at the edge where the driven transaction went in
  bit   holdoff_done = 1'b0;

  complex_arithmetic_unit_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // clamp an exact value to the signed field range
  function automatic logic [DW-1:0] clamp_part(input logic signed [127:0] v,
                                                inout bit sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (DW - 1)) - 1;
    lo = -(128'sd1 <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // drop the fraction of a product sum, nearest step, ties away from zero
  function automatic logic signed [127:0] round_frac(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (128'sd1 <<< (FB - 1))) >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  // num * 2^FB / den rounded ties away from zero, den positive
  function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
                                                           input logic signed [127:0] den);
    logic signed [127:0] m;
    m = (num < 0) ? -num : num;
    m = ((m <<< (FB + 1)) + den) / (den <<< 1);
    return (num < 0) ? -m : m;
  endfunction

  function automatic res_t complex_result(input op_t op);
    res_t r;
    bit sat;
    logic signed [127:0] ar, ai, br, bi, xr, xi, den;
    r = '{default: '0};
    sat = 1'b0;
    ar = 128'(signed'(op.a_re));
    ai = 128'(signed'(op.a_im));
    br = 128'(signed'(op.b_re));
    bi = 128'(signed'(op.b_im));
    xr = 0;
    xi = 0;
    case (op.action)
      cau_pkg::ACT_ADD: begin
        xr = ar + br;
        xi = ai + bi;
      end
      cau_pkg::ACT_SUB: begin
        xr = ar - br;
        xi = ai - bi;
      end
      cau_pkg::ACT_MUL: begin
        xr = round_frac(ar * br - ai * bi);
        xi = round_frac(ar * bi + ai * br);
      end
      cau_pkg::ACT_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.status = cau_pkg::ST_DIVZ;
        else begin
          xr = scaled_quotient(ar * br + ai * bi, den);
          xi = scaled_quotient(ai * br - ar * bi, den);
        end
      end
      cau_pkg::ACT_EQ: r.cmp = (op.a_re == op.b_re) && (op.a_im == op.b_im);
      cau_pkg::ACT_NE: r.cmp = !((op.a_re == op.b_re) && (op.a_im == op.b_im));
      default: ;
    endcase
    if (op.action <= cau_pkg::ACT_DIV && r.status == cau_pkg::ST_OK) begin
      r.re = clamp_part(xr, sat);
      r.im = clamp_part(xi, sat);
      if (sat) r.status = cau_pkg::ST_SAT;
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_operand();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return $urandom();
    if (k < 7) return DW'($signed($urandom_range(0, 1 << (FB + 4))) - (1 << (FB + 3)));
    if (k == 7) return DW'($signed($urandom_range(0, 15)) - 8);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '1;
      default: return '0;
    endcase
  endfunction

  // 0 most of the time, a few short gaps, rarely a long one
  function automatic int gap_len(input bit quiet);
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // ---------------- stimulus ----------------
  initial begin
    op_t op;
    logic [DW-1:0] mx, mn;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    // directed: every action, extremes, saturation, divide by zero, compares
    pending_ops.push_back('{cau_pkg::ACT_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                            32'hFFFF_0000, 0});
    pending_ops.push_back('{cau_pkg::ACT_ADD, mx, mn, 32'h1, mn, 0});
    pending_ops.push_back('{cau_pkg::ACT_SUB, mn, mx, 32'h1, mn, 0});
    pending_ops.push_back('{cau_pkg::ACT_SUB, 32'h0, 32'h0, mn, mn, 0});
    pending_ops.push_back('{cau_pkg::ACT_MUL, 32'h0002_8000, 32'hFFFF_0000, 32'h0001_8000,
                            32'h0000_4000, 0});
    pending_ops.push_back('{cau_pkg::ACT_MUL, mn, mn, mn, mn, 0});
    pending_ops.push_back('{cau_pkg::ACT_MUL, mx, mx, mx, mn, 0});
    // tie
    pending_ops.push_back('{cau_pkg::ACT_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0, 0});
    // neg tie
    pending_ops.push_back('{cau_pkg::ACT_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0, 0});
    pending_ops.push_back('{cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 0});
    pending_ops.push_back('{cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                            32'h0, 0});
    pending_ops.push_back('{cau_pkg::ACT_DIV, mx, mn, 32'h1, 32'h0, 0});
    pending_ops.push_back('{cau_pkg::ACT_DIV, mn, mn, mn, mn, 0});
    pending_ops.push_back('{cau_pkg::ACT_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0, 0});
    pending_ops.push_back('{cau_pkg::ACT_DIV, 32'h1, 32'h1, 32'h1, 32'hFFFF_FFFF, 0});
    pending_ops.push_back('{cau_pkg::ACT_EQ, 32'h1234_5678, mn, 32'h1234_5678, mn, 0});
    pending_ops.push_back('{cau_pkg::ACT_EQ, 32'h1234_5678, mn, 32'h1234_5679, mn, 0});
    pending_ops.push_back('{cau_pkg::ACT_NE, mx, 32'h0, mx, 32'h0, 0});
    pending_ops.push_back('{cau_pkg::ACT_NE, mx, 32'h0, mx, 32'h1, 0});
    pending_ops.push_back('{3'd6, mx, mn, mx, mn, 0});
    pending_ops.push_back('{3'd7, '1, '1, '1, '1, 0});
    for (int i = 0; i < N_RANDOM; i++) begin
      op.action = $urandom_range(0, 99) < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      op.a_re = rand_operand();
      op.a_im = rand_operand();
      op.b_re = rand_operand();
      op.b_im = rand_operand();
      if (op.action == cau_pkg::ACT_DIV && $urandom_range(0, 9) == 0) begin
        op.b_re = '0;
        op.b_im = '0;
      end
      if ((op.action == cau_pkg::ACT_EQ || op.action == cau_pkg::ACT_NE) &&
          $urandom_range(0, 1)) begin
        op.b_re = op.a_re;
        op.b_im = op.a_im;
        if ($urandom_range(0, 3) == 0) op.b_im[$urandom_range(0, DW-1)] ^= 1'b1;
      end
      op.drain_first = (i == 500);  // the sender pauses here until everything is back
      pending_ops.push_back(op);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_ops.size() == 0 && !in_tvalid);
    wait (expected_res.size() == 0);
    repeat (TAIL) @(posedge clk);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------- driver: inputs change on the falling edge ----------------
  int  send_gap = 0;
  bit  send_quiet = 1'b0;

  always @(negedge clk) begin
    op_t op;
    bit  offer;
    offer = 1'b0;
    if (rst_n && (!in_tvalid || taken)) begin
      if (send_gap > 0) send_gap--;
      else if (pending_ops.size() > 0 &&
               (!pending_ops[0].drain_first || expected_res.size() == 0)) begin
        op = pending_ops.pop_front();
        offer = 1'b1;
        in_tdata <= IN_TDATA_W'({op.b_im, op.b_re, op.a_im, op.a_re});
        in_tuser <= op.action;
        if ($urandom_range(0, 79) == 0) send_quiet = !send_quiet;
        send_gap = gap_len(send_quiet);
      end
      in_tvalid <= offer;
    end
    taken = 1'b0;
  end

  // ---------------- receiver: random backpressure plus one long hold ----------------
  int  recv_gap = 0;
  int  hold_cnt = 0;

  always @(negedge clk) begin
    if (!holdoff_done && n_accepted >= 300) begin
      // long stall while the sender keeps going, so the unit fills and stops in_tready
      hold_cnt++;
      out_tready <= 1'b0;
      if (hold_cnt >= 150) holdoff_done = 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      recv_gap = gap_len($urandom_range(0, 3) == 0);
    end
  end

  // ---------------- monitor: sampled at the rising edge ----------------
  always @(posedge clk) begin
    res_t want;
    op_t  seen;
    cycle++;
    if (cycle > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n) begin
      // accepted input transaction: queue its expected result
      if (in_tvalid && in_tready) begin
        seen.action = in_tuser;
        {seen.b_im, seen.b_re, seen.a_im, seen.a_re} = in_tdata[4*DW-1:0];
        seen.drain_first = 1'b0;
        expected_res.push_back(complex_result(seen));
        n_accepted++;
        taken = 1'b1;
      end
      // accepted result transaction: compare against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_res.size() == 0) begin
          $error("result transaction with nothing expected: tdata %h tuser %h",
                 out_tdata, out_tuser);
          n_errors++;
        end else begin
          want = expected_res.pop_front();
          if (out_tdata[DW-1:0] !== want.re) begin
            $error("result_re: expected %h, got %h", want.re, out_tdata[DW-1:0]);
            n_errors++;
          end
          if (out_tdata[2*DW-1:DW] !== want.im) begin
            $error("result_im: expected %h, got %h", want.im, out_tdata[2*DW-1:DW]);
            n_errors++;
          end
          if (out_tuser[0] !== want.cmp) begin
            $error("compare_true: expected %b, got %b", want.cmp, out_tuser[0]);
            n_errors++;
          end
          if (out_tuser[2:1] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser[2:1]);
            n_errors++;
          end
        end
      end
    end
  end

endmodule
